>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is high
`define MPSL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// same with a message of the caller
`define MPSL_ASSERT_MSG(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: %s", msg);

`endif

>>> src/mpsl_pkg.sv
// ----------------------------------------------------------------------------
// mpsl_pkg
// types and constants of the midpoint subdivision line unit
// ----------------------------------------------------------------------------
package mpsl_pkg;

  localparam int COORD_W = 5;
  localparam int SEG_W   = 4 * COORD_W;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t by;
    coord_t bx;
    coord_t ay;
    coord_t ax;
  } seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENDS,
    ST_SPLIT,
    ST_POP,
    ST_FLUSH
  } state_t;

  // sequencer to output stage
  typedef struct packed {
    logic   load;
    logic   push;
    logic   flush;
    coord_t x;
    coord_t y;
  } emit_ev_t;

  function automatic coord_t span(input coord_t a, input coord_t b);
    span = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic coord_t midpoint(input coord_t a, input coord_t b);
    logic [COORD_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    midpoint = sum[COORD_W:1];
  endfunction

endpackage

>>> src/mpsl_ram.sv
// ----------------------------------------------------------------------------
// mpsl_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mpsl_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/mpsl_emit.sv
// ----------------------------------------------------------------------------
// mpsl_emit
// output stage: holds one pixel back so the final one can carry last_pixel
// ----------------------------------------------------------------------------
module mpsl_emit import mpsl_pkg::*; #(
  parameter int GRID_SIZE = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  emit_ev_t ev,
  output logic     pixel_strobe,
  output coord_t   pixel_x,
  output coord_t   pixel_y,
  output logic     last_pixel
);

  localparam int CW = $clog2(GRID_SIZE + 1);

  coord_t        pend_x;
  coord_t        pend_y;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_strobe <= 1'b0;
      count        <= '0;
    end else begin
      pixel_strobe <= 1'b0;
      if (ev.load) begin
        pend_x <= ev.x;
        pend_y <= ev.y;
        count  <= CW'(1);
      end else if (ev.push && (count < CW'(GRID_SIZE))) begin
        pixel_strobe <= 1'b1;
        pixel_x      <= pend_x;
        pixel_y      <= pend_y;
        last_pixel   <= 1'b0;
        pend_x       <= ev.x;
        pend_y       <= ev.y;
        count        <= count + CW'(1);
      end else if (ev.flush) begin
        pixel_strobe <= 1'b1;
        pixel_x      <= pend_x;
        pixel_y      <= pend_y;
        last_pixel   <= 1'b1;
      end
    end
  end

endmodule

>>> src/mpsl_ctrl.sv
// ----------------------------------------------------------------------------
// mpsl_ctrl
// subdivision sequencer: pops segments from the stack ram, splits, pushes
// ----------------------------------------------------------------------------
module mpsl_ctrl import mpsl_pkg::*; #(
  parameter int STACK_DEPTH = 8,
  localparam int AW         = $clog2(STACK_DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  coord_t           start_x,
  input  coord_t           start_y,
  input  coord_t           end_x,
  input  coord_t           end_y,
  output logic             busy,
  output emit_ev_t         ev,
  output logic             we,
  output logic [AW-1:0]    waddr,
  output logic [SEG_W-1:0] wdata,
  output logic             re,
  output logic [AW-1:0]    raddr,
  input  logic [SEG_W-1:0] rdata
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);

  state_t         state, state_next;
  logic [SPW-1:0] sp, sp_next;
  seg_t           cur, cur_next;
  logic           use_rd, use_rd_next;

  seg_t           seg;
  seg_t           left;
  seg_t           right;
  coord_t         mid_x;
  coord_t         mid_y;
  logic           split;
  logic           room0;
  logic           room1;
  logic [SPW-1:0] sp1;
  logic [SPW-1:0] sp_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      sp     <= '0;
      use_rd <= 1'b0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      use_rd <= use_rd_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  always_comb begin
    seg   = use_rd ? seg_t'(rdata) : cur;
    split = (span(seg.ax, seg.bx) > coord_t'(1)) || (span(seg.ay, seg.by) > coord_t'(1));
    mid_x = midpoint(seg.ax, seg.bx);
    mid_y = midpoint(seg.ay, seg.by);
    right = '{by: seg.by, bx: seg.bx, ay: mid_y, ax: mid_x};
    left  = '{by: mid_y, bx: mid_x, ay: seg.ay, ax: seg.ax};
    room0 = sp < SPW'(STACK_DEPTH);
    sp1   = room0 ? (sp + SPW'(1)) : sp;
    room1 = sp1 < SPW'(STACK_DEPTH);
    sp_m1 = sp - SPW'(1);

    state_next  = state;
    sp_next     = sp;
    cur_next    = cur;
    use_rd_next = use_rd;
    ev          = '0;
    we          = 1'b0;
    waddr       = sp[AW-1:0];
    wdata       = SEG_W'(right);
    re          = 1'b0;
    raddr       = sp_m1[AW-1:0];

    case (state)
      ST_IDLE: begin
        if (start) begin
          ev.load     = 1'b1;
          ev.x        = start_x;
          ev.y        = start_y;
          cur_next    = '{by: end_y, bx: end_x, ay: start_y, ax: start_x};
          use_rd_next = 1'b0;
          sp_next     = '0;
          state_next  = ST_ENDS;
        end
      end
      ST_ENDS: begin
        ev.push    = 1'b1;
        ev.x       = cur.bx;
        ev.y       = cur.by;
        state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (split) begin
          ev.push = 1'b1;
          ev.x    = mid_x;
          ev.y    = mid_y;
          we      = room0;
          sp_next = sp1;
          if (room1) begin
            // left half goes straight back in without a stack trip
            cur_next    = left;
            use_rd_next = 1'b0;
          end else begin
            state_next = ST_POP;
          end
        end else if (sp == '0) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        re          = 1'b1;
        sp_next     = sp_m1;
        use_rd_next = 1'b1;
        state_next  = ST_SPLIT;
      end
      ST_FLUSH: begin
        ev.flush   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> src/midpoint_subdivision_line_unit.sv
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_unit
// line rasterizer by midpoint subdivision on a segment stack held in ram
//
//   beat     ports                                   handshake
//   line in  start_x start_y end_x end_y             start / busy
//   pixel    pixel_x pixel_y last_pixel              pixel_strobe
//
// each split is done in the split state; a segment fetched back from the
// stack passes the pop state, which reads the ram, and then the split
// state; start and end pixels appear first
// pixels leave one per cycle at most; the receiver cannot stall
// synchronous reset returns to idle with an empty stack
// ----------------------------------------------------------------------------
module midpoint_subdivision_line_unit import mpsl_pkg::*; #(
  parameter int GRID_SIZE   = 32,
  parameter int STACK_DEPTH = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   busy,
  output logic   pixel_strobe,
  output coord_t pixel_x,
  output coord_t pixel_y,
  output logic   last_pixel
);

  localparam int AW = $clog2(STACK_DEPTH);

  emit_ev_t         ev;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [SEG_W-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [SEG_W-1:0] rdata;

  mpsl_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .start_x(start_x),
    .start_y(start_y),
    .end_x  (end_x),
    .end_y  (end_y),
    .busy   (busy),
    .ev     (ev),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  mpsl_ram #(
    .WIDTH(SEG_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  mpsl_emit #(
    .GRID_SIZE(GRID_SIZE)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .pixel_strobe(pixel_strobe),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last_pixel  (last_pixel)
  );

endmodule

>>> src/mpsl_checker.sv
// ----------------------------------------------------------------------------
// mpsl_checker
// port level checks of the line unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpsl_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic [4:0] start_x,
  input logic [4:0] start_y,
  input logic [4:0] end_x,
  input logic [4:0] end_y,
  input logic       busy,
  input logic       pixel_strobe,
  input logic [4:0] pixel_x,
  input logic [4:0] pixel_y,
  input logic       last_pixel
);

  // an accepted line is worked on right away
  `MPSL_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)

  // the start pixel leads every line
  `MPSL_ASSERT_MSG(a_first_pixel, clk, rst,
    (start && !busy) |-> ##2 (pixel_strobe && !last_pixel &&
      pixel_x == $past(start_x, 2) && pixel_y == $past(start_y, 2)),
    "first beat is not the start pixel")

  // the last beat of a line and the return to idle coincide
  `MPSL_ASSERT(a_last_idle, clk, rst, (pixel_strobe && last_pixel) |-> !busy)
  `MPSL_ASSERT(a_idle_last, clk, rst, $fell(busy) |-> (pixel_strobe && last_pixel))

  // inner beats only while a line is in work
  `MPSL_ASSERT(a_inner_busy, clk, rst, (pixel_strobe && !last_pixel) |-> busy)

endmodule

bind midpoint_subdivision_line_unit mpsl_checker u_mpsl_checker (.*);
